@@ rtl/irbpe_pkg.sv @@
// ----------------------------------------------------------------------------
// irbpe_pkg
// Shared types, register indexes and constants for the infrared beacon pulse
// encoder.
// ----------------------------------------------------------------------------
package irbpe_pkg;

    typedef logic [2:0] t_cfg_idx;

    localparam int CFG_DATA_BITS = 12;
    localparam int CODE_BITS     = 8;
    localparam int TPB_BITS      = 4;
    localparam int FEND_BITS     = 12;
    localparam int SLOTS         = 40;
    localparam int CHANNELS      = 4;

    localparam t_cfg_idx CFG_CODE_LEFT      = 3'd0;
    localparam t_cfg_idx CFG_CODE_MID_LEFT  = 3'd1;
    localparam t_cfg_idx CFG_CODE_MID_RIGHT = 3'd2;
    localparam t_cfg_idx CFG_CODE_RIGHT     = 3'd3;
    localparam t_cfg_idx CFG_TICKS_PER_BIT  = 3'd4;
    localparam t_cfg_idx CFG_FRAME_END      = 3'd5;

    localparam logic [CODE_BITS-1:0] RST_CODE_LEFT      = 8'h48;
    localparam logic [CODE_BITS-1:0] RST_CODE_MID_LEFT  = 8'h44;
    localparam logic [CODE_BITS-1:0] RST_CODE_MID_RIGHT = 8'h42;
    localparam logic [CODE_BITS-1:0] RST_CODE_RIGHT     = 8'h50;
    localparam logic [TPB_BITS-1:0]  RST_TICKS_PER_BIT  = 4'd7;
    localparam logic [FEND_BITS-1:0] RST_FRAME_END      = 12'd460;

    // slot groups, read lsb first, bit set = emitter off
    localparam logic [4:0] PAT_ONE  = 5'h10;
    localparam logic [4:0] PAT_ZERO = 5'h1e;

    typedef logic [SLOTS-1:0] t_pattern;

    function automatic t_pattern expand_code(input logic [CODE_BITS-1:0] code);
        t_pattern p;
        p = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            p[5*i +: 5] = code[CODE_BITS-1-i] ? PAT_ONE : PAT_ZERO;
        end
        return p;
    endfunction

endpackage

@@ rtl/ir_beacon_pulse_encoder_core.sv @@
// ----------------------------------------------------------------------------
// ir_beacon_pulse_encoder_core
// Four-channel infrared beacon transmitter: each tick word advances the frame
// counter and yields one word of emitter drives and a sending flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  tick      in         i_tick_valid / o_tick_ready     i_tick
//  result    out        o_res_valid  / i_res_ready      o_left_on .. o_right_on,
//                                                       o_sending
//  config    in         i_cfg_wr_en (no wait)           i_cfg_index, i_cfg_wdata
//
//  one word per cycle while results are taken: frame update and result are
//  computed in the accept cycle and land in the result register.
//  the tick channel is ready whenever the result register is empty or is
//  being taken in the same cycle, so a stalled result stalls the input.
//  synchronous active-low reset restores register defaults, clears the frame
//  counter, slot counter, patterns and emitters; no clearing pass.
// ----------------------------------------------------------------------------
module ir_beacon_pulse_encoder_core #(
    parameter int FRAME_COUNT_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tick_valid,
    output logic                                o_tick_ready,
    input  logic                                i_tick,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_left_on,
    output logic                                o_mid_left_on,
    output logic                                o_mid_right_on,
    output logic                                o_right_on,
    output logic                                o_sending,
    input  logic                                i_cfg_wr_en,
    input  irbpe_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [irbpe_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);
    import irbpe_pkg::*;

    localparam int FCB = FRAME_COUNT_BITS;
    // compare width covers the counter, frame_end and the slot window
    localparam int CMP_BITS = ((FCB > FEND_BITS) ? FCB : FEND_BITS) + 1;
    localparam logic [CMP_BITS-1:0] END_CAP = CMP_BITS'((64'd1 << FCB) - 64'd2);

    // configuration
    logic [CODE_BITS-1:0] r_code [CHANNELS];
    logic [TPB_BITS-1:0]  r_ticks_per_bit;
    logic [FEND_BITS-1:0] r_frame_end;

    // frame state
    logic [FCB-1:0]              r_frame_tick, n_frame_tick;
    logic [TPB_BITS-1:0]         r_slot_tick, n_slot_tick;
    t_pattern [CHANNELS-1:0]     r_pat, n_pat;
    logic [CHANNELS-1:0]         r_emit, n_emit;
    logic                        n_sending;

    // result register
    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_emit;
    logic                r_out_sending;

    logic                in_acc;
    logic [TPB_BITS-1:0] tpb;
    logic [CMP_BITS-1:0] window, end_lo, end_eff, ft_now, ft_inc_x;
    logic [FCB-1:0]      ft_inc;
    logic [TPB_BITS-1:0] slot_base, slot_inc;
    t_pattern [CHANNELS-1:0] pat_cur;

    assign o_tick_ready = !r_out_valid || i_res_ready;
    assign in_acc       = i_tick_valid && o_tick_ready;

    always_comb begin
        tpb      = (r_ticks_per_bit == '0) ? TPB_BITS'(1) : r_ticks_per_bit;
        // 40 * tpb
        window   = CMP_BITS'({tpb, 5'b0}) + CMP_BITS'({tpb, 3'b0});
        end_lo   = (CMP_BITS'(r_frame_end) < window + CMP_BITS'(1))
                   ? window + CMP_BITS'(1) : CMP_BITS'(r_frame_end);
        end_eff  = (end_lo > END_CAP) ? END_CAP : end_lo;
        ft_now   = CMP_BITS'(r_frame_tick);
        ft_inc   = r_frame_tick + FCB'(1);
        ft_inc_x = CMP_BITS'(ft_inc);

        // first tick of a frame latches the codes
        for (int k = 0; k < CHANNELS; k++) begin
            pat_cur[k] = (ft_inc == FCB'(1)) ? expand_code(r_code[k]) : r_pat[k];
        end
        slot_base = (ft_inc == FCB'(1)) ? '0 : r_slot_tick;
        slot_inc  = slot_base + TPB_BITS'(1);

        n_frame_tick = r_frame_tick;
        n_slot_tick  = r_slot_tick;
        n_pat        = r_pat;
        n_emit       = r_emit;
        n_sending    = (ft_now != '0) && (ft_now <= window);

        if (i_tick) begin
            n_frame_tick = ft_inc;
            n_sending    = 1'b0;
            if ((ft_inc_x <= window) && (ft_inc_x <= end_eff)) begin
                n_sending = 1'b1;
                for (int k = 0; k < CHANNELS; k++) begin
                    n_emit[k] = !pat_cur[k][0];
                end
                if (slot_inc >= tpb) begin
                    n_slot_tick = '0;
                    for (int k = 0; k < CHANNELS; k++) begin
                        n_pat[k] = pat_cur[k] >> 1;
                    end
                end else begin
                    n_slot_tick = slot_inc;
                    n_pat       = pat_cur;
                end
            end else if ((ft_inc_x == window + CMP_BITS'(1)) && (ft_inc_x <= end_eff)) begin
                n_emit = '0;
            end else if (ft_inc_x > end_eff) begin
                n_frame_tick = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code[0]       <= RST_CODE_LEFT;
            r_code[1]       <= RST_CODE_MID_LEFT;
            r_code[2]       <= RST_CODE_MID_RIGHT;
            r_code[3]       <= RST_CODE_RIGHT;
            r_ticks_per_bit <= RST_TICKS_PER_BIT;
            r_frame_end     <= RST_FRAME_END;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CODE_LEFT:      r_code[0] <= i_cfg_wdata[CODE_BITS-1:0];
                CFG_CODE_MID_LEFT:  r_code[1] <= i_cfg_wdata[CODE_BITS-1:0];
                CFG_CODE_MID_RIGHT: r_code[2] <= i_cfg_wdata[CODE_BITS-1:0];
                CFG_CODE_RIGHT:     r_code[3] <= i_cfg_wdata[CODE_BITS-1:0];
                CFG_TICKS_PER_BIT:  r_ticks_per_bit <= i_cfg_wdata[TPB_BITS-1:0];
                CFG_FRAME_END:      r_frame_end <= i_cfg_wdata[FEND_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_tick  <= '0;
            r_slot_tick   <= '0;
            r_pat         <= '0;
            r_emit        <= '0;
            r_out_valid   <= 1'b0;
            r_out_emit    <= '0;
            r_out_sending <= 1'b0;
        end else begin
            if (in_acc) begin
                r_frame_tick  <= n_frame_tick;
                r_slot_tick   <= n_slot_tick;
                r_pat         <= n_pat;
                r_emit        <= n_emit;
                r_out_emit    <= n_emit;
                r_out_sending <= n_sending;
                r_out_valid   <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_left_on      = r_out_emit[0];
    assign o_mid_left_on  = r_out_emit[1];
    assign o_mid_right_on = r_out_emit[2];
    assign o_right_on     = r_out_emit[3];
    assign o_sending      = r_out_sending;

    // every accepted word yields a result word on the next cycle
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted word did not produce a result");

    // an idle word leaves the frame untouched
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_tick |=> $stable(r_frame_tick) && $stable(r_emit)
                              && $stable(r_slot_tick))
        else $error("word without tick changed frame state");

    // a frame always opens on counter value one
    a_frame_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_tick && r_frame_tick == '0 |=> r_frame_tick == FCB'(1))
        else $error("frame did not open after counter restart");

    // a pending sending result always belongs to a live frame
    a_sending_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sending |-> r_frame_tick != '0)
        else $error("sending flag with idle frame counter");

    // emitter drives in the result match the held emitter state
    a_emit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_emit == r_emit)
        else $error("result emitters differ from emitter state");

endmodule
